### sv/plm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_pkg: shared types and constants of the positional list engine
// Sizes of the list and of the transaction fields, command and status codes,
// and the operation that each storage cell performs in a cycle.
// ----------------------------------------------------------------------------
package plm_pkg;

   // List geometry
   localparam int DEPTH = 16;
   localparam int WIDTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int LEN_W = $clog2(DEPTH + 1);

   // Transaction field widths
   localparam int ACTION_W = 3;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND = 3'd0,
      ACT_INSERT = 3'd1,
      ACT_POP    = 3'd2,
      ACT_READ   = 3'd3,
      ACT_FIND   = 3'd4,
      ACT_REMOVE = 3'd5
   } plm_action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } plm_status_type;

   // What a cell loads at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_TAKE_LEFT,
      CELL_TAKE_RIGHT
   } plm_cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } plm_state_type;

endpackage : plm_pkg
`default_nettype wire

### sv/plm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_cell: one storage cell of the list
// Holds one entry, takes a new value or a neighbor's entry when the list
// opens or closes a gap, and compares its entry against a search key.
// ----------------------------------------------------------------------------
module plm_cell (
   input  wire                           clock,
   input  var   plm_pkg::plm_cell_op_type cell_op,
   input  wire  [plm_pkg::WIDTH-1:0]     load_value,
   input  wire  [plm_pkg::WIDTH-1:0]     left_value,
   input  wire  [plm_pkg::WIDTH-1:0]     right_value,
   input  wire  [plm_pkg::WIDTH-1:0]     key_value,
   output logic [plm_pkg::WIDTH-1:0]     entry_value,
   output logic                          match
);
   import plm_pkg::*;

   logic [WIDTH-1:0] entry_ff;
   logic [WIDTH-1:0] entry_in;

   // Select the next entry
   always_comb begin
      unique case (cell_op)
         CELL_LOAD:       entry_in = load_value;
         CELL_TAKE_LEFT:  entry_in = left_value;
         CELL_TAKE_RIGHT: entry_in = right_value;
         default:         entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Compare against the search key
   assign entry_value = entry_ff;
   assign match       = (entry_ff == key_value);

endmodule : plm_cell
`default_nettype wire

### sv/positional_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list with insert and delete by index
// Keeps up to DEPTH values in a row of cells and runs append, insert, pop,
// read, find and remove commands, one result per command.
// ----------------------------------------------------------------------------
// Each transaction has an accept cycle and an apply cycle: in the accept cycle
// every cell compares its entry with the request value and the match vector is
// registered; in the apply cycle the first match is picked, the cells shift or
// load in parallel and the result goes to the output register. A new request
// is taken only once the previous one has been applied. The apply cycle waits
// only while a previous result sits unclaimed in the output register. The list
// holds no valid state apart from its length.
// ----------------------------------------------------------------------------
module positional_list_engine (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [plm_pkg::ACTION_W-1:0]     req_action,
   input  wire  [plm_pkg::POS_W-1:0]        req_position,
   input  wire                              req_from_end,
   input  wire  [plm_pkg::WIDTH-1:0]        req_value,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [plm_pkg::WIDTH-1:0]        rsp_result_value,
   output logic [plm_pkg::IDX_W-1:0]        rsp_result_position,
   output logic                             rsp_found,
   output logic [plm_pkg::STATUS_W-1:0]     rsp_status,
   output logic [plm_pkg::LEN_W-1:0]        rsp_length
);
   import plm_pkg::*;

   plm_state_type   state_ff, state_in;
   logic            apply_fire;

   logic [LEN_W-1:0]    len_ff, len_in;
   logic [ACTION_W-1:0] cmd_action_ff;
   logic [POS_W-1:0]    cmd_position_ff;
   logic                cmd_from_end_ff;
   logic [WIDTH-1:0]    cmd_value_ff;
   logic [DEPTH-1:0]    match_ff;

   logic [WIDTH-1:0]    entry_value [DEPTH];
   logic [DEPTH-1:0]    cell_match;
   plm_cell_op_type     cell_op [DEPTH];

   logic                rsp_valid_ff;
   logic [WIDTH-1:0]    rsp_value_ff;
   logic [IDX_W-1:0]    rsp_position_ff;
   logic                rsp_found_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LEN_W-1:0]    rsp_length_ff;

   // Apply-cycle decode
   logic [DEPTH-1:0]    first_hot;
   logic [IDX_W-1:0]    first_idx;
   logic                any_match;
   logic [IDX_W-1:0]    rd_idx;
   logic [WIDTH-1:0]    rd_value;
   logic [WIDTH-1:0]    res_value;
   logic [IDX_W-1:0]    res_position;
   logic                res_found;
   plm_status_type      res_status;
   logic                do_load, do_shift_up, do_shift_down;
   logic [LEN_W-1:0]    tgt;
   logic [LEN_W-1:0]    pos_l;

   // Row of cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WIDTH-1:0] left_w, right_w;
      if (g == 0) begin : g_first
         assign left_w = cmd_value_ff;
      end else begin : g_inner_l
         assign left_w = entry_value[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_w = entry_value[g];
      end else begin : g_inner_r
         assign right_w = entry_value[g+1];
      end
      plm_cell u_cell (
         .clock       (clock),
         .cell_op     (cell_op[g]),
         .load_value  (cmd_value_ff),
         .left_value  (left_w),
         .right_value (right_w),
         .key_value   (req_value),
         .entry_value (entry_value[g]),
         .match       (cell_match[g])
      );
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_APPLY;
         ST_APPLY: if (apply_fire) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      apply_fire = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latch the command and the masked match vector on accept
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_action_ff   <= req_action;
         cmd_position_ff <= req_position;
         cmd_from_end_ff <= req_from_end;
         cmd_value_ff    <= req_value;
         for (int i = 0; i < DEPTH; i++) begin
            match_ff[i] <= cell_match[i] && (LEN_W'(i) < len_ff);
         end
      end
   end

   // Pick the first match and encode its position
   always_comb begin
      first_hot = match_ff & (~match_ff + DEPTH'(1));
      any_match = |match_ff;
      first_idx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_hot[i]) first_idx = first_idx | IDX_W'(i);
      end
   end

   // Decode the command against the current length
   always_comb begin
      pos_l         = LEN_W'(cmd_position_ff);
      res_value     = '0;
      res_position  = '0;
      res_found     = 1'b0;
      res_status    = STAT_OK;
      do_load       = 1'b0;
      do_shift_up   = 1'b0;
      do_shift_down = 1'b0;
      tgt           = '0;
      rd_idx        = cmd_position_ff[IDX_W-1:0];
      len_in        = len_ff;
      unique case (cmd_action_ff)
         ACT_APPEND: begin
            if (len_ff >= LEN_W'(DEPTH)) begin
               res_status = STAT_FULL;
            end else begin
               do_load = 1'b1;
               tgt     = len_ff;
               len_in  = len_ff + LEN_W'(1);
            end
         end
         ACT_INSERT: begin
            if (pos_l > len_ff) begin
               res_status = STAT_RANGE;
            end else if (len_ff >= LEN_W'(DEPTH)) begin
               res_status = STAT_FULL;
            end else begin
               do_load     = 1'b1;
               do_shift_up = 1'b1;
               tgt         = pos_l;
               len_in      = len_ff + LEN_W'(1);
            end
         end
         ACT_POP: begin
            if (cmd_from_end_ff) begin
               if (len_ff == '0) begin
                  res_status = STAT_RANGE;
               end else begin
                  tgt    = len_ff - LEN_W'(1);
                  rd_idx = tgt[IDX_W-1:0];
                  do_shift_down = 1'b1;
                  res_value     = rd_value;
                  len_in        = len_ff - LEN_W'(1);
               end
            end else if (pos_l >= len_ff) begin
               res_status = STAT_RANGE;
            end else begin
               tgt           = pos_l;
               do_shift_down = 1'b1;
               res_value     = rd_value;
               len_in        = len_ff - LEN_W'(1);
            end
         end
         ACT_READ: begin
            if (pos_l >= len_ff) begin
               res_status = STAT_RANGE;
            end else begin
               res_value = rd_value;
            end
         end
         ACT_FIND: begin
            res_found    = any_match;
            res_position = first_idx;
         end
         ACT_REMOVE: begin
            res_found = any_match;
            if (any_match) begin
               tgt           = LEN_W'(first_idx);
               do_shift_down = 1'b1;
               len_in        = len_ff - LEN_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign rd_value = entry_value[rd_idx];

   // Drive each cell's operation
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_op[i] = CELL_HOLD;
         if (apply_fire) begin
            if (do_load && LEN_W'(i) == tgt) begin
               cell_op[i] = CELL_LOAD;
            end else if (do_shift_up && LEN_W'(i) > tgt) begin
               cell_op[i] = CELL_TAKE_LEFT;
            end else if (do_shift_down && LEN_W'(i) >= tgt) begin
               cell_op[i] = CELL_TAKE_RIGHT;
            end
         end
      end
   end

   // Advance the length
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (apply_fire) begin
         len_ff <= len_in;
      end
   end

   // Output register: hold until the transaction is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (apply_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (apply_fire) begin
         rsp_value_ff    <= res_value;
         rsp_position_ff <= res_position;
         rsp_found_ff    <= res_found;
         rsp_status_ff   <= res_status;
         rsp_length_ff   <= len_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_value    = rsp_value_ff;
   assign rsp_result_position = rsp_position_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_length          = rsp_length_ff;

`ifndef ASSERT_OFF
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(DEPTH))
      else $error("list length exceeds depth");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_FULL) |-> rsp_length_ff == LEN_W'(DEPTH))
      else $error("full status with list not full");

   a_len_only_on_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_APPLY) |=> $stable(len_ff))
      else $error("length changed outside apply cycle");

   a_apply_result: assert property (@(posedge clock) disable iff (reset)
      apply_fire |=> rsp_valid_ff)
      else $error("applied command produced no result");
`endif

endmodule : positional_list_engine
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the positional list engine
// Drives append, insert, pop, read, find, remove and spare action codes through the
// request channel with bursty traffic, tracks a shadow copy of the list to
// predict every response, and checks responses in order against it while the
// response side stalls in shifting patterns and once holds off for a while.
// ----------------------------------------------------------------------------
module testbench;
   import plm_pkg::*;

   // Action codes the block has no operation for
   localparam logic [ACTION_W-1:0] ACT_RESERVED_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_RESERVED_7 = 3'd7;

   // Response stall patterns, used in rotation
   localparam int RX_ALWAYS = 0;
   localparam int RX_MOSTLY = 1;
   localparam int RX_THIRD  = 2;

   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 300000;

   typedef struct packed {
      logic [WIDTH-1:0] value;
      logic [IDX_W-1:0] position;
      logic             found;
      plm_status_type   status;
      logic [LEN_W-1:0] length;
   } list_outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [ACTION_W-1:0] req_action = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic                req_from_end = 1'b0;
   logic [WIDTH-1:0]    req_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [WIDTH-1:0]    rsp_result_value;
   logic [IDX_W-1:0]    rsp_result_position;
   logic                rsp_found;
   logic [STATUS_W-1:0] rsp_status;
   logic [LEN_W-1:0]    rsp_length;

   // Shadow list and outstanding predictions
   logic [WIDTH-1:0] shadow_list [DEPTH];
   int               shadow_len = 0;
   list_outcome_type expected_outcomes [$];

   logic [WIDTH-1:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                         32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                                         32'h7FFF_FFFF, 32'h0000_FFFF};

   int  error_count = 0;
   int  results_checked = 0;
   int  full_outcomes = 0;
   int  range_outcomes = 0;
   int  commands_by_action [8] = '{default: 0};
   int  cycle_count = 0;
   int  burst_left = 0;
   bit  sender_gaps = 1'b1;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   int  holdoffs_done = 0;
   int  rx_cycle = 0;

   positional_list_engine DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_position        (req_position),
      .req_from_end        (req_from_end),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_result_value    (rsp_result_value),
      .rsp_result_position (rsp_result_position),
      .rsp_found           (rsp_found),
      .rsp_status          (rsp_status),
      .rsp_length          (rsp_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Remove one entry from the shadow list and close the hole
   function automatic logic [WIDTH-1:0] take_entry(input int slot);
      logic [WIDTH-1:0] taken;
      int               i;
      taken = shadow_list[slot];
      for (i = slot; i < shadow_len - 1; i++)
         shadow_list[i] = shadow_list[i + 1];
      shadow_len--;
      return taken;
   endfunction

   // Apply one command to the shadow list and return the response it gives
   function automatic list_outcome_type apply_command(input logic [ACTION_W-1:0] action,
                                                      input logic [POS_W-1:0] position,
                                                      input logic from_end,
                                                      input logic [WIDTH-1:0] value);
      list_outcome_type outcome;
      int               slot;
      int               i;
      outcome = '0;
      outcome.status = STAT_OK;
      case (action)
         ACT_APPEND: begin
            if (shadow_len >= DEPTH) begin
               outcome.status = STAT_FULL;
            end else begin
               shadow_list[shadow_len] = value;
               shadow_len++;
            end
         end
         ACT_INSERT: begin
            if (position > shadow_len) begin
               outcome.status = STAT_RANGE;
            end else if (shadow_len >= DEPTH) begin
               outcome.status = STAT_FULL;
            end else begin
               for (i = shadow_len; i > position; i--)
                  shadow_list[i] = shadow_list[i - 1];
               shadow_list[position] = value;
               shadow_len++;
            end
         end
         ACT_POP: begin
            slot = from_end ? shadow_len - 1 : int'(position);
            if (slot < 0 || slot >= shadow_len)
               outcome.status = STAT_RANGE;
            else
               outcome.value = take_entry(slot);
         end
         ACT_READ: begin
            if (position >= shadow_len)
               outcome.status = STAT_RANGE;
            else
               outcome.value = shadow_list[position];
         end
         ACT_FIND, ACT_REMOVE: begin
            // first match wins
            slot = -1;
            for (i = shadow_len - 1; i >= 0; i--)
               if (shadow_list[i] == value) slot = i;
            if (slot >= 0) begin
               outcome.found = 1'b1;
               if (action == ACT_FIND)
                  outcome.position = slot[IDX_W-1:0];
               else
                  void'(take_entry(slot));
            end
         end
         default: ;
      endcase
      if (outcome.status == STAT_FULL) full_outcomes++;
      if (outcome.status == STAT_RANGE) range_outcomes++;
      outcome.length = shadow_len[LEN_W-1:0];
      return outcome;
   endfunction

   // Offer one command, wait for its transaction, record the prediction
   task automatic issue_command(input logic [ACTION_W-1:0] action,
                                input logic [POS_W-1:0] position,
                                input logic from_end,
                                input logic [WIDTH-1:0] value);
      int gap;
      if (sender_gaps && burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_valid    <= 1'b1;
      req_action   <= action;
      req_position <= position;
      req_from_end <= from_end;
      req_value    <= value;
      do @(posedge clock); while (!req_ready);
      expected_outcomes.push_back(apply_command(action, position, from_end, value));
      commands_by_action[action]++;
   endtask

   // Build a random command biased toward growing or shrinking the list
   task automatic issue_random_command(input bit growing);
      logic [ACTION_W-1:0] action;
      logic [POS_W-1:0]    position;
      logic [WIDTH-1:0]    value;
      int                  pick;
      pick = $urandom_range(0, 99);
      if (pick == 0)
         action = ACT_RESERVED_6;
      else if (pick == 1)
         action = ACT_RESERVED_7;
      else if (growing)
         action = pick < 40 ? ACT_APPEND : pick < 65 ? ACT_INSERT : pick < 75 ? ACT_POP :
                  pick < 83 ? ACT_READ : pick < 92 ? ACT_FIND : ACT_REMOVE;
      else
         action = pick < 15 ? ACT_APPEND : pick < 25 ? ACT_INSERT : pick < 55 ? ACT_POP :
                  pick < 68 ? ACT_READ : pick < 80 ? ACT_FIND : ACT_REMOVE;
      if ($urandom_range(0, 4) != 0)
         position = POS_W'($urandom_range(0, shadow_len));
      else
         position = POS_W'($urandom_range(0, 31));
      if ((action == ACT_FIND || action == ACT_REMOVE) && shadow_len > 0 &&
          $urandom_range(0, 3) != 0)
         value = shadow_list[$urandom_range(0, shadow_len - 1)];
      else if ($urandom_range(0, 4) < 3)
         value = value_pool[$urandom_range(0, 7)];
      else
         value = $urandom;
      issue_command(action, position, 1'($urandom_range(0, 1)), value);
   endtask

   // Drop valid and hold until every response is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      int i;
      // empty list corner cases
      issue_command(ACT_POP, 5'd0, 1'b1, 32'h0);
      issue_command(ACT_READ, 5'd0, 1'b0, 32'h0);
      issue_command(ACT_REMOVE, 5'd0, 1'b0, 32'h1234_5678);
      issue_command(ACT_INSERT, 5'd1, 1'b0, 32'h7);
      // fill: head, tail, middle, then appends
      issue_command(ACT_INSERT, 5'd0, 1'b0, 32'h0000_0000);
      issue_command(ACT_APPEND, 5'd0, 1'b0, 32'hFFFF_FFFF);
      issue_command(ACT_INSERT, 5'd2, 1'b1, 32'hA5A5_A5A5);
      issue_command(ACT_INSERT, 5'd1, 1'b0, 32'h5A5A_5A5A);
      for (i = 4; i < DEPTH; i++)
         issue_command(ACT_APPEND, POS_W'(31 - i), i[0], 32'h0001_0000 + i);
      // full list corner cases
      issue_command(ACT_APPEND, 5'd0, 1'b0, 32'hDEAD_BEEF);
      issue_command(ACT_INSERT, 5'd16, 1'b0, 32'hDEAD_BEEF);
      issue_command(ACT_INSERT, 5'd17, 1'b0, 32'hDEAD_BEEF);
      issue_command(ACT_READ, 5'd15, 1'b0, 32'h0);
      issue_command(ACT_FIND, 5'd0, 1'b0, 32'hFFFF_FFFF);
      issue_command(ACT_REMOVE, 5'd0, 1'b0, 32'h0000_0000);
      issue_command(ACT_POP, 5'd31, 1'b1, 32'h0);
      issue_command(ACT_POP, 5'd31, 1'b0, 32'h0);
      issue_command(ACT_POP, 5'd0, 1'b0, 32'h0);
      issue_command(ACT_RESERVED_6, 5'd3, 1'b1, 32'hFFFF_FFFF);
      issue_command(ACT_RESERVED_7, 5'd0, 1'b0, 32'h0);
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count);
      int n;
      int phase_left;
      bit growing;
      growing = 1'b1;
      phase_left = $urandom_range(40, 120);
      for (n = 0; n < count; n++) begin
         if (phase_left == 0) begin
            growing = !growing;
            phase_left = $urandom_range(40, 120);
         end
         phase_left--;
         issue_random_command(growing);
      end
      wait_for_results();
   endtask

   task automatic test_back_to_back(input int count);
      int n;
      sender_gaps = 1'b0;
      for (n = 0; n < count; n++)
         issue_random_command((n / 50) % 2 == 0);
      sender_gaps = 1'b1;
      wait_for_results();
   endtask

   // Stall the response side while requests keep coming
   task automatic test_backpressure();
      int n;
      sender_gaps = 1'b0;
      hold_request = 1'b1;
      for (n = 0; n < 30; n++)
         issue_random_command(n < 20);
      sender_gaps = 1'b1;
      wait_for_results();
   endtask

   // Response side stall patterns
   always @(posedge clock) begin
      rx_cycle++;
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         holdoffs_done++;
         rsp_ready <= 1'b0;
      end else begin
         case ((rx_cycle / 256) % 4)
            RX_ALWAYS: rsp_ready <= 1'b1;
            RX_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_THIRD:  rsp_ready <= (rx_cycle % 3 == 0);
            default:   rsp_ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   task automatic compare_field(input string field, input logic [WIDTH-1:0] want,
                                input logic [WIDTH-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   // Check each response transaction against the oldest prediction
   always @(posedge clock) begin : check_responses
      list_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outcomes.size() == 0) begin
            error_count++;
            $display("%0t: response with nothing outstanding, expected none, actual value %h",
                     $time, rsp_result_value);
         end else begin
            want = expected_outcomes.pop_front();
            results_checked++;
            compare_field("result_value", want.value, rsp_result_value);
            compare_field("result_position", WIDTH'(want.position), WIDTH'(rsp_result_position));
            compare_field("found", WIDTH'(want.found), WIDTH'(rsp_found));
            compare_field("status", WIDTH'(want.status), WIDTH'(rsp_status));
            compare_field("length", WIDTH'(want.length), WIDTH'(rsp_length));
         end
      end
   end

   initial begin
      foreach (shadow_list[i]) shadow_list[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_traffic(1400);
      test_backpressure();
      test_back_to_back(250);
      $write("Covered %0d commands: append %0d, insert %0d, pop %0d, ",
             commands_by_action.sum(), commands_by_action[ACT_APPEND],
             commands_by_action[ACT_INSERT], commands_by_action[ACT_POP]);
      $display("read %0d, find %0d, remove %0d, spare codes %0d",
               commands_by_action[ACT_READ], commands_by_action[ACT_FIND],
               commands_by_action[ACT_REMOVE],
               commands_by_action[ACT_RESERVED_6] + commands_by_action[ACT_RESERVED_7]);
      $display("Checked %0d responses, %0d list-full and %0d out-of-range, %0d response hold-offs",
               results_checked, full_outcomes, range_outcomes, holdoffs_done);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
